@@ rtl/core/bawm_pkg.sv @@
// Shared types and constants of the bump allocator with a mark stack.
// Used by the register bank, the controller, the datapath and the top level.
// Depends on nothing.
`default_nettype none

package bawm_pkg;

    // Sizing of the mark stack and the alignment range
    localparam int MARK_DEPTH     = 64;
    localparam int MIN_ALIGN_LOG2 = 0;
    localparam int MAX_ALIGN_LOG2 = 12;

    // Field widths
    localparam int ADDR_W  = 48;
    localparam int SIZE_W  = 32;
    localparam int ALIGN_W = 4;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;
    // Padding never exceeds 2^15 - 1 for a 4-bit alignment exponent
    localparam int PAD_W   = 16;
    localparam int DEPTH_W = $clog2(MARK_DEPTH + 1);
    localparam int IDX_W   = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    typedef enum logic [0:0] {
        REG_BASE     = 1'b0,
        REG_CAPACITY = 1'b1
    } reg_idx_t;

    localparam logic [SIZE_W-1:0] CAPACITY_RESET = 32'd65536;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_RECORD = 2'd1,
        OP_UNWIND = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_BAD      = 3'd4
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic    accept;
        logic    load;
        logic    align;
        logic    commit;
        status_t result;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic bad_req;
        logic full;
        logic empty;
        logic no_space;
    } dp_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/bawm_regs.sv @@
// Configuration register bank: region base and capacity behind an APB-style port.
// Depends on bawm_pkg.
`default_nettype none

module bawm_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bawm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [bawm_pkg::PDATA_W-1:0]   pwdata,
    output logic      [bawm_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    output logic      [bawm_pkg::ADDR_W-1:0]    region_base,
    output logic      [bawm_pkg::SIZE_W-1:0]    region_capacity
);
    import bawm_pkg::*;

    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] capacity_reg;
    reg_idx_t          idx;
    logic              wr_en;

    // Registers sit on 8-byte boundaries
    assign idx    = reg_idx_t'(paddr[3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            capacity_reg <= CAPACITY_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_BASE:     base_reg     <= pwdata[ADDR_W-1:0];
                REG_CAPACITY: capacity_reg <= pwdata[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_BASE:     prdata = PDATA_W'(base_reg);
            REG_CAPACITY: prdata = PDATA_W'(capacity_reg);
            default:      prdata = '0;
        endcase
    end

    assign region_base     = base_reg;
    assign region_capacity = capacity_reg;

endmodule

`default_nettype wire

@@ rtl/core/bawm_ctrl.sv @@
// Request sequencer: steps each request through load, align and commit,
// picks the outcome code from datapath flags and raises the result strobe.
// Depends on bawm_pkg.
`default_nettype none

module bawm_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire bawm_pkg::dp_flags_t    flags,
    output logic                        busy,
    output logic                        done,
    output bawm_pkg::ctrl_cmd_t         cmd
);
    import bawm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOAD   = 4'b0010,
        S_ALIGN  = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t  state_reg, state_next;
    logic    done_reg, done_next;
    status_t result;

    // Choose the outcome of the request
    always_comb
    begin
        case (flags.op)
            OP_ALLOC:
            begin
                if (flags.bad_req)
                    result = ST_BAD;
                else if (flags.no_space)
                    result = ST_NO_SPACE;
                else
                    result = ST_OK;
            end
            OP_RECORD: result = flags.full  ? ST_FULL  : ST_OK;
            OP_UNWIND: result = flags.empty ? ST_EMPTY : ST_OK;
            default:   result = ST_OK;
        endcase
    end

    // Advance through the steps of one request
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (start) state_next = S_LOAD;
            S_LOAD:   state_next = S_ALIGN;
            S_ALIGN:  state_next = S_COMMIT;
            S_COMMIT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign cmd.accept = start && (state_reg == S_IDLE);
    assign cmd.load   = (state_reg == S_LOAD);
    assign cmd.align  = (state_reg == S_ALIGN);
    assign cmd.commit = (state_reg == S_COMMIT);
    assign cmd.result = result;
    assign done_next  = cmd.commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

@@ rtl/core/bawm_dp.sv @@
// Allocator datapath: request registers, used count, mark stack memory,
// alignment arithmetic and result registers.
// Depends on bawm_pkg.
`default_nettype none

module bawm_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bawm_pkg::ctrl_cmd_t            cmd,
    input  wire logic [bawm_pkg::OP_W-1:0]      op,
    input  wire logic [bawm_pkg::SIZE_W-1:0]    request_size,
    input  wire logic [bawm_pkg::ALIGN_W-1:0]   align_log2,
    input  wire logic [bawm_pkg::ADDR_W-1:0]    region_base,
    input  wire logic [bawm_pkg::SIZE_W-1:0]    region_capacity,
    output bawm_pkg::dp_flags_t                 flags,
    output logic      [bawm_pkg::ADDR_W-1:0]    granted_address,
    output logic      [bawm_pkg::STAT_W-1:0]    status,
    output logic      [bawm_pkg::SIZE_W-1:0]    bytes_in_use
);
    import bawm_pkg::*;

    // Request beat
    op_t                 op_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [ALIGN_W-1:0]  align_reg;

    // Allocator state
    logic [SIZE_W-1:0]   used_reg, used_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [SIZE_W-1:0]   mark_mem [MARK_DEPTH];
    logic [SIZE_W-1:0]   mark_rd_reg;

    // Intermediate stages
    logic [ADDR_W-1:0]   cur_reg;
    logic [SIZE_W-1:0]   room_reg;
    logic [ADDR_W-1:0]   aligned_reg;
    logic [SIZE_W:0]     total_reg;

    // Results
    logic [ADDR_W-1:0]   granted_reg;
    status_t             status_reg;
    logic [SIZE_W-1:0]   in_use_reg;

    logic [DEPTH_W-1:0]  depth_dec;
    logic [PAD_W-1:0]    mask;
    logic [PAD_W-1:0]    pad;
    logic                ok;

    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign mask      = (PAD_W'(1) << align_reg) - PAD_W'(1);
    assign pad       = (PAD_W'(0) - cur_reg[PAD_W-1:0]) & mask;
    assign ok        = (cmd.result == ST_OK);

    // Flags for the controller
    assign flags.op       = op_reg;
    assign flags.bad_req  = (size_reg == '0)
                         || (align_reg < ALIGN_W'(MIN_ALIGN_LOG2))
                         || (align_reg > ALIGN_W'(MAX_ALIGN_LOG2));
    assign flags.full     = (depth_reg >= DEPTH_W'(MARK_DEPTH));
    assign flags.empty    = (depth_reg == '0);
    assign flags.no_space = (total_reg > {1'b0, room_reg});

    // Capture the request beat
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= op_t'(op);
            size_reg  <= request_size;
            align_reg <= align_log2;
        end
    end

    // Load step: current address, free room, top mark
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg     <= region_base + ADDR_W'(used_reg);
            room_reg    <= (region_capacity > used_reg) ? (region_capacity - used_reg) : '0;
            mark_rd_reg <= mark_mem[depth_dec[IDX_W-1:0]];
        end
    end

    // Align step: padding, aligned address, total bytes taken
    always_ff @(posedge clk)
    begin
        if (cmd.align)
        begin
            aligned_reg <= cur_reg + ADDR_W'(pad);
            total_reg   <= {1'b0, size_reg} + (SIZE_W+1)'(pad);
        end
    end

    // Push a mark on a successful record
    always_ff @(posedge clk)
    begin
        if (cmd.commit && ok && (op_reg == OP_RECORD))
            mark_mem[depth_reg[IDX_W-1:0]] <= used_reg;
    end

    // Next used count and stack depth at commit
    always_comb
    begin
        used_next  = used_reg;
        depth_next = depth_reg;
        if (ok)
        begin
            case (op_reg)
                OP_ALLOC:  used_next = used_reg + total_reg[SIZE_W-1:0];
                OP_RECORD: depth_next = depth_reg + DEPTH_W'(1);
                OP_UNWIND:
                begin
                    depth_next = depth_dec;
                    used_next  = mark_rd_reg;
                end
                OP_CLEAR:
                begin
                    used_next  = '0;
                    depth_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            depth_reg <= '0;
        end
        else if (cmd.commit)
        begin
            used_reg  <= used_next;
            depth_reg <= depth_next;
        end
    end

    // Hold the result for the strobe cycle
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            granted_reg <= (ok && (op_reg == OP_ALLOC)) ? aligned_reg : '0;
            status_reg  <= cmd.result;
            in_use_reg  <= used_next;
        end
    end

    assign granted_address = granted_reg;
    assign status          = status_reg;
    assign bytes_in_use    = in_use_reg;

endmodule

`default_nettype wire

@@ rtl/core/bump_allocator_with_marks.sv @@
// Top level of the bump allocator with a mark stack.
// Depends on bawm_pkg, bawm_regs, bawm_ctrl and bawm_dp.
//
//   channel   handshake                       beat
//   -------   -----------------------------   -----------------------------------------
//   request   start && !busy                  op, request_size, align_log2
//   result    done (one cycle, no stall)      granted_address, status, bytes_in_use
//   config    psel & penable & pwrite         paddr (8-byte step), pwdata; prdata reads
//
// A request is accepted from idle, then passes load (base add,
// room and mark stack read), align (padding and sums) and commit (compare and update).
// The result strobe comes in the cycle after commit, when busy is already low again,
// so a new request is taken only once the sequencer is back in idle.
// Reset clears the used count, the mark count and the registers to their defaults.
// The receiver cannot stall; each result is valid only while done is high.
`default_nettype none

module bump_allocator_with_marks (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [bawm_pkg::OP_W-1:0]      op,
    input  wire logic [bawm_pkg::SIZE_W-1:0]    request_size,
    input  wire logic [bawm_pkg::ALIGN_W-1:0]   align_log2,
    output logic                                done,
    output logic      [bawm_pkg::ADDR_W-1:0]    granted_address,
    output logic      [bawm_pkg::STAT_W-1:0]    status,
    output logic      [bawm_pkg::SIZE_W-1:0]    bytes_in_use,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bawm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [bawm_pkg::PDATA_W-1:0]   pwdata,
    output logic      [bawm_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);
    import bawm_pkg::*;

    logic [ADDR_W-1:0] region_base;
    logic [SIZE_W-1:0] region_capacity;
    ctrl_cmd_t         cmd;
    dp_flags_t         flags;

    bawm_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .region_base     (region_base),
        .region_capacity (region_capacity)
    );

    bawm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    bawm_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .op              (op),
        .request_size    (request_size),
        .align_log2      (align_log2),
        .region_base     (region_base),
        .region_capacity (region_capacity),
        .flags           (flags),
        .granted_address (granted_address),
        .status          (status),
        .bytes_in_use    (bytes_in_use)
    );

endmodule

`default_nettype wire

@@ dv/bump_allocator_with_marks_tb.sv @@
// Self-checking testbench for bump_allocator_with_marks: APB register setup, then
// directed and random alloc, record, unwind and clear requests, each checked on its result.
// Depends on bawm_pkg and the bump_allocator_with_marks RTL.
module bump_allocator_with_marks_tb;

    import bawm_pkg::*;

    localparam int          QUIET_LIMIT = 1000;
    localparam logic [63:0] ADDR_MASK   = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        status_t           st;
        logic [SIZE_W-1:0] in_use;
    } grant_t;

    // Allocator predictor plus the queue of grants it expects
    class alloc_scoreboard;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] capacity;
        logic [SIZE_W-1:0] used;
        logic [SIZE_W-1:0] marks [MARK_DEPTH];
        int                depth;
        grant_t            expected_grants [$];
        int                faults;

        function new();
            base     = '0;
            capacity = CAPACITY_RESET;
            used     = '0;
            depth    = 0;
            faults   = 0;
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction

        // Mirror a register write; unknown indexes are dropped
        function void write_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] value);
            case (addr >> 3)
                REG_BASE:     base     = value[ADDR_W-1:0];
                REG_CAPACITY: capacity = value[SIZE_W-1:0];
                default:      ;
            endcase
        endfunction

        // Advance the allocator state for one request and queue its grant
        function void note_request(op_t kind, logic [SIZE_W-1:0] size, logic [ALIGN_W-1:0] lg);
            logic [63:0] mask;
            logic [63:0] cur;
            logic [63:0] rounded;
            logic [63:0] pad;
            logic [63:0] total;
            logic [63:0] room;
            grant_t      g;
            g.addr = '0;
            g.st   = ST_OK;
            case (kind)
                OP_ALLOC:
                begin
                    if (size == '0 || int'(lg) < MIN_ALIGN_LOG2 || int'(lg) > MAX_ALIGN_LOG2)
                    begin
                        g.st = ST_BAD;
                    end
                    else
                    begin
                        mask    = (64'd1 << lg) - 64'd1;
                        cur     = ({16'd0, base} + {32'd0, used}) & ADDR_MASK;
                        rounded = (cur + mask) & ~mask;
                        pad     = rounded - cur;
                        total   = {32'd0, size} + pad;
                        room    = (capacity > used) ? {32'd0, capacity - used} : 64'd0;
                        if (total > room)
                        begin
                            g.st = ST_NO_SPACE;
                        end
                        else
                        begin
                            used   = used + total[SIZE_W-1:0];
                            g.addr = rounded[ADDR_W-1:0];
                        end
                    end
                end
                OP_RECORD:
                begin
                    if (depth >= MARK_DEPTH)
                    begin
                        g.st = ST_FULL;
                    end
                    else
                    begin
                        marks[depth] = used;
                        depth++;
                    end
                end
                OP_UNWIND:
                begin
                    if (depth == 0)
                    begin
                        g.st = ST_EMPTY;
                    end
                    else
                    begin
                        depth--;
                        used = marks[depth];
                    end
                end
                default:
                begin
                    used  = '0;
                    depth = 0;
                end
            endcase
            g.in_use = used;
            expected_grants.push_back(g);
        endfunction

        task note_fault(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            faults++;
        endtask

        // Compare one result beat with the oldest expected grant
        task check_result(logic [ADDR_W-1:0] addr, logic [STAT_W-1:0] st,
                          logic [SIZE_W-1:0] in_use);
            grant_t g;
            if (expected_grants.size() == 0)
            begin
                note_fault($sformatf("result beat with nothing outstanding, status %0d", st));
                return;
            end
            g = expected_grants.pop_front();
            if (addr !== g.addr)
                note_fault($sformatf("granted_address %h, want %h", addr, g.addr));
            if (st !== g.st)
                note_fault($sformatf("status %0d, want %0d", st, g.st));
            if (in_use !== g.in_use)
                note_fault($sformatf("bytes_in_use %h, want %h", in_use, g.in_use));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     op;
    logic [SIZE_W-1:0]   request_size;
    logic [ALIGN_W-1:0]  align_log2;
    logic                done;
    logic [ADDR_W-1:0]   granted_address;
    logic [STAT_W-1:0]   status;
    logic [SIZE_W-1:0]   bytes_in_use;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    alloc_scoreboard     sb = new();
    int                  quiet_cycles = 0;
    bit                  gaps_on;

    bump_allocator_with_marks dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .request_size    (request_size),
        .align_log2      (align_log2),
        .done            (done),
        .granted_address (granted_address),
        .status          (status),
        .bytes_in_use    (bytes_in_use),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sample every handshake at the edge; count cycles with no beat of any kind
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(granted_address, status, bytes_in_use);
            if (start && !busy)
                sb.note_request(op_t'(op), request_size, align_log2);
            if (psel && penable && pwrite && pready)
                sb.write_register(paddr, pwdata);
        end
        if (rst_n && (done || (start && !busy) || (psel && penable && pwrite && pready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("bump_allocator_with_marks verification failed");
        $finish;
    end

    // Drive one request beat, with an occasional gap ahead of it, and hold until taken
    task send_request(op_t kind, logic [SIZE_W-1:0] size, logic [ALIGN_W-1:0] lg);
        if (gaps_on && $urandom_range(99) < 7)
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        start        <= 1'b1;
        op           <= kind;
        request_size <= size;
        align_log2   <= lg;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    // Drop start and wait for every outstanding grant plus the pipeline depth
    task drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup beat, access beat, then psel drops and the port idles
    task apb_write(reg_idx_t which, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(which) * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram the region, then issue a random mix weighted per op
    task run_phase(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] cap, int items,
                   int w_alloc, int w_rec, int w_unw, bit gaps);
        int                 pick;
        op_t                kind;
        logic [SIZE_W-1:0]  size;
        logic [ALIGN_W-1:0] lg;
        drain_results();
        apb_write(REG_BASE, {16'd0, base});
        apb_write(REG_CAPACITY, {32'd0, cap});
        gaps_on = gaps;
        repeat (items)
        begin
            pick = $urandom_range(99);
            if (pick < w_alloc)
                kind = OP_ALLOC;
            else if (pick < w_alloc + w_rec)
                kind = OP_RECORD;
            else if (pick < w_alloc + w_rec + w_unw)
                kind = OP_UNWIND;
            else
                kind = OP_CLEAR;
            // Mostly small sizes so the region lasts; some zero, some full width
            pick = $urandom_range(99);
            if (pick < 5)
                size = '0;
            else if (pick < 15)
                size = $urandom();
            else if (pick < 35)
                size = $urandom_range(cap, 1);
            else
                size = $urandom_range(64, 1);
            if ($urandom_range(99) < 8)
                lg = ALIGN_W'($urandom_range(15, MAX_ALIGN_LOG2 + 1));
            else
                lg = ALIGN_W'($urandom_range(MAX_ALIGN_LOG2, MIN_ALIGN_LOG2));
            send_request(kind, size, lg);
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        op           <= OP_ALLOC;
        request_size <= '0;
        align_log2   <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        gaps_on      = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: empty stack, bad allocs, padding, exact fill
        send_request(OP_UNWIND, 32'd0, 4'd0);
        send_request(OP_ALLOC, 32'd0, 4'd0);
        send_request(OP_ALLOC, 32'd1, 4'd13);
        send_request(OP_ALLOC, 32'd1, 4'd15);
        send_request(OP_ALLOC, 32'd1, 4'd0);
        send_request(OP_ALLOC, 32'd3, 4'd12);
        send_request(OP_RECORD, 32'd0, 4'd0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 4'd0);
        send_request(OP_ALLOC, 32'd100, 4'd4);
        send_request(OP_UNWIND, 32'd0, 4'd0);
        send_request(OP_ALLOC, 32'd61437, 4'd0);
        send_request(OP_ALLOC, 32'd1, 4'd0);
        send_request(OP_CLEAR, 32'hFFFF_FFFF, 4'hF);

        // Top of the address space: rounding wraps past 2^48
        drain_results();
        apb_write(REG_BASE, 64'h0000_FFFF_FFFF_FFFF);
        apb_write(REG_CAPACITY, 64'h0000_0000_FFFF_FFFF);
        send_request(OP_ALLOC, 32'd1, 4'd4);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 4'd0);
        send_request(OP_ALLOC, 32'hFFFF_FFFD, 4'd0);
        send_request(OP_RECORD, 32'd0, 4'd0);
        send_request(OP_CLEAR, 32'd0, 4'd0);

        // Shrink capacity under the current use, then the one-byte region
        drain_results();
        apb_write(REG_BASE, 64'd0);
        apb_write(REG_CAPACITY, 64'd1000);
        send_request(OP_ALLOC, 32'd900, 4'd0);
        drain_results();
        apb_write(REG_CAPACITY, 64'd1);
        send_request(OP_ALLOC, 32'd1, 4'd0);
        send_request(OP_UNWIND, 32'd0, 4'd0);
        send_request(OP_CLEAR, 32'd0, 4'd0);
        send_request(OP_ALLOC, 32'd1, 4'd0);
        send_request(OP_ALLOC, 32'd1, 4'd0);

        // Random phases across region settings; the record-heavy one runs with no gaps
        run_phase(48'd0, 32'd65536, 80, 55, 18, 17, 1'b1);
        run_phase(48'({$urandom(), $urandom()}), $urandom(), 80, 55, 18, 17, 1'b1);
        run_phase(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 60, 60, 15, 15, 1'b1);
        run_phase(48'({$urandom(), $urandom()}), 32'd1, 40, 50, 20, 20, 1'b1);
        run_phase(48'h1000, 32'h0010_0000, 150, 30, 55, 15, 1'b0);
        run_phase(48'({$urandom(), $urandom()}), $urandom_range(4096, 1), 80, 55, 18, 17, 1'b1);
        run_phase(48'd0, 32'd65536, 80, 45, 25, 25, 1'b1);

        drain_results();
        if (sb.faults == 0)
            $display("bump_allocator_with_marks verification clean");
        else
            $display("bump_allocator_with_marks verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bawm_pkg.sv
rtl/core/bawm_regs.sv
rtl/core/bawm_ctrl.sv
rtl/core/bawm_dp.sv
rtl/core/bump_allocator_with_marks.sv
dv/bump_allocator_with_marks_tb.sv
